FILE: sv/octant_direction_angle_top_macros.svh
// ----------------------------------------------------------------------------
// octant direction angle assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef OCTANT_DIRECTION_ANGLE_TOP_MACROS_SVH
`define OCTANT_DIRECTION_ANGLE_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ODA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ODA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/oda_pkg.sv
// ----------------------------------------------------------------------------
// oda_pkg
// widths, flag codes and pipeline item types for the octant direction angle
// ----------------------------------------------------------------------------
package oda_pkg;

  localparam int COORD_W   = 24;
  localparam int SPAN_W    = COORD_W + 1;   // span reaches 2^24
  localparam int REM_W     = SPAN_W + 1;    // remainder stays below twice the major span
  localparam int FRAC_BITS = 8;
  localparam int RATIO_W   = FRAC_BITS + 1; // ratio 0 to 256
  localparam int ANGLE_W   = 13;

  // flag codes, steep in bit 2, y swapped in bit 1, x swapped in bit 0
  localparam logic [2:0] FLAGS_NONE     = 3'd0;
  localparam logic [2:0] FLAGS_X        = 3'd1;
  localparam logic [2:0] FLAGS_Y        = 3'd2;
  localparam logic [2:0] FLAGS_XY       = 3'd3;
  localparam logic [2:0] FLAGS_STEEP    = 3'd4;
  localparam logic [2:0] FLAGS_STEEP_X  = 3'd5;
  localparam logic [2:0] FLAGS_STEEP_Y  = 3'd6;
  localparam logic [2:0] FLAGS_STEEP_XY = 3'd7;

  typedef struct packed {
    logic steep;
    logic yswap;
    logic xswap;
  } oda_flags_t;

  typedef struct packed {
    oda_flags_t           flags;
    logic [SPAN_W-1:0]    major;
    logic [REM_W-1:0]     rem;
    logic [RATIO_W-1:0]   quo;
  } oda_div_t;

endpackage

FILE: sv/octant_direction_angle_top.sv
// ----------------------------------------------------------------------------
// octant_direction_angle_top
// approximate direction angle between two points, fully pipelined
// ----------------------------------------------------------------------------
// Takes one point pair per cycle while the output is not stalled and
// returns one angle per item, in order, through fourteen register stages.
// The depth is set by the ratio divider, nine registered restoring steps
// of one quotient bit each, behind three stages that form the spans and
// octant flags and ahead of two stages that scale the ratio to an eighth
// turn and map it onto the circle. Each stage takes a new item whenever it
// is empty or its successor moves, so bubbles close up under stall and a
// waiting result does not block entry. FULL_TURN sets the angle units; a
// full turn can appear as a result and larger angles are cut to the 13-bit
// output.

module octant_direction_angle_top #(
  parameter int FULL_TURN = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [oda_pkg::COORD_W-1:0]  first_x,
  input  logic signed [oda_pkg::COORD_W-1:0]  first_y,
  input  logic signed [oda_pkg::COORD_W-1:0]  second_x,
  input  logic signed [oda_pkg::COORD_W-1:0]  second_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [oda_pkg::ANGLE_W-1:0]         direction_angle
);

  logic               in_ready;
  logic               chain_valid [oda_pkg::RATIO_W+1];
  logic               chain_ready [oda_pkg::RATIO_W+1];
  oda_pkg::oda_div_t  chain_item  [oda_pkg::RATIO_W+1];

  assign in_stall = !in_ready;

  oda_span u_span (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .first_x   (first_x),
    .first_y   (first_y),
    .second_x  (second_x),
    .second_y  (second_y),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_item  (chain_item[0])
  );

  for (genvar i = 0; i < oda_pkg::RATIO_W; i++) begin : g_div
    oda_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_item   (chain_item[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_item  (chain_item[i+1])
    );
  end

  oda_scale #(
    .FULL_TURN (FULL_TURN)
  ) u_scale (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (chain_valid[oda_pkg::RATIO_W]),
    .in_ready        (chain_ready[oda_pkg::RATIO_W]),
    .in_item         (chain_item[oda_pkg::RATIO_W]),
    .out_valid       (out_valid),
    .out_ready       (!out_stall),
    .direction_angle (direction_angle)
  );

endmodule

FILE: sv/oda_span.sv
// ----------------------------------------------------------------------------
// oda_span
// three stages: coordinate differences, spans and swap flags, major and minor
// ----------------------------------------------------------------------------
`include "octant_direction_angle_top_macros.svh"

module oda_span (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [oda_pkg::COORD_W-1:0]  first_x,
  input  logic signed [oda_pkg::COORD_W-1:0]  first_y,
  input  logic signed [oda_pkg::COORD_W-1:0]  second_x,
  input  logic signed [oda_pkg::COORD_W-1:0]  second_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output oda_pkg::oda_div_t                   out_item
);

  logic                        s1_valid;
  logic [oda_pkg::SPAN_W-1:0]  dx;
  logic [oda_pkg::SPAN_W-1:0]  dy;
  logic                        s2_valid;
  logic [oda_pkg::SPAN_W-1:0]  sx;
  logic [oda_pkg::SPAN_W-1:0]  sy;
  logic                        xswap;
  logic                        yswap;
  logic                        s1_ready;
  logic                        s2_ready;
  logic                        s3_ready;
  logic [oda_pkg::SPAN_W-1:0]  dx_next;
  logic [oda_pkg::SPAN_W-1:0]  dy_next;
  logic [oda_pkg::SPAN_W-1:0]  sx_next;
  logic [oda_pkg::SPAN_W-1:0]  sy_next;
  logic                        steep_next;
  oda_pkg::oda_div_t           out_item_next;

  assign s3_ready = !out_valid || out_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    dx_next = {second_x[oda_pkg::COORD_W-1], second_x} - {first_x[oda_pkg::COORD_W-1], first_x};
    dy_next = {second_y[oda_pkg::COORD_W-1], second_y} - {first_y[oda_pkg::COORD_W-1], first_y};
    // magnitude plus one, negative case folds the two increments together
    sx_next = dx[oda_pkg::SPAN_W-1] ? (~dx + oda_pkg::SPAN_W'(2)) : (dx + oda_pkg::SPAN_W'(1));
    sy_next = dy[oda_pkg::SPAN_W-1] ? (~dy + oda_pkg::SPAN_W'(2)) : (dy + oda_pkg::SPAN_W'(1));
    steep_next = sy > sx;
    out_item_next.flags.steep = steep_next;
    out_item_next.flags.yswap = yswap;
    out_item_next.flags.xswap = xswap;
    out_item_next.major = steep_next ? sy : sx;
    out_item_next.rem   = oda_pkg::REM_W'(steep_next ? sx : sy);
    out_item_next.quo   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      dx <= dx_next;
      dy <= dy_next;
    end
    if (s2_ready && s1_valid) begin
      sx    <= sx_next;
      sy    <= sy_next;
      xswap <= dx[oda_pkg::SPAN_W-1];
      yswap <= dy[oda_pkg::SPAN_W-1];
    end
    if (s3_ready && s2_valid) begin
      out_item <= out_item_next;
    end
  end

  `ODA_ASSERT_NEXT(a_span_load, in_valid && in_ready, s1_valid, "span stage dropped an item")
  `ODA_ASSERT_SAME(a_span_order, out_valid,
    (out_item.major != '0) && (out_item.rem <= oda_pkg::REM_W'(out_item.major)),
    "minor span exceeds major span or major span is zero")

endmodule

FILE: sv/oda_div_step.sv
// ----------------------------------------------------------------------------
// oda_div_step
// one registered restoring step of the ratio divider, one quotient bit
// ----------------------------------------------------------------------------
`include "octant_direction_angle_top_macros.svh"

module oda_div_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  oda_pkg::oda_div_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output oda_pkg::oda_div_t  out_item
);

  logic                       ge;
  logic [oda_pkg::REM_W-1:0]  diff;
  oda_pkg::oda_div_t          out_item_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    ge   = in_item.rem >= oda_pkg::REM_W'(in_item.major);
    diff = ge ? (in_item.rem - oda_pkg::REM_W'(in_item.major)) : in_item.rem;
    out_item_next.flags = in_item.flags;
    out_item_next.major = in_item.major;
    out_item_next.rem   = {diff[oda_pkg::REM_W-2:0], 1'b0};
    out_item_next.quo   = {in_item.quo[oda_pkg::RATIO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= out_item_next;
    end
  end

  `ODA_ASSERT_SAME(a_div_rem_bound, out_valid,
    out_item.rem < {out_item.major, 1'b0},
    "divider remainder escaped twice the major span")

endmodule

FILE: sv/oda_scale.sv
// ----------------------------------------------------------------------------
// oda_scale
// two stages: ratio scaled to an eighth turn, then octant mapping to the angle
// ----------------------------------------------------------------------------
`include "octant_direction_angle_top_macros.svh"

module oda_scale #(
  parameter int FULL_TURN = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  oda_pkg::oda_div_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [oda_pkg::ANGLE_W-1:0]   direction_angle
);

  localparam int QUARTER  = FULL_TURN / 4;
  localparam int EIGHTH   = QUARTER / 2;
  localparam int HALF     = FULL_TURN / 2;
  localparam int THREEQ   = QUARTER * 3;
  localparam int BASE_W   = $clog2(EIGHTH + 1);
  localparam int PROD_W   = oda_pkg::RATIO_W + BASE_W;
  localparam int TURN_W   = $clog2(FULL_TURN + 1);
  localparam int CALC_W   = (TURN_W > oda_pkg::ANGLE_W) ? TURN_W : oda_pkg::ANGLE_W;

  localparam logic [CALC_W-1:0] QUARTER_C = CALC_W'(QUARTER);
  localparam logic [CALC_W-1:0] HALF_C    = CALC_W'(HALF);
  localparam logic [CALC_W-1:0] THREEQ_C  = CALC_W'(THREEQ);
  localparam logic [CALC_W-1:0] FULL_C    = CALC_W'(FULL_TURN);

  logic                  m_valid;
  logic [BASE_W-1:0]     base;
  logic [2:0]            code;
  logic                  m_ready;
  logic                  a_ready;
  logic [PROD_W-1:0]     prod;
  logic [CALC_W-1:0]     base_c;
  logic [CALC_W-1:0]     angle;
  logic [CALC_W-1:0]     angle_next;

  assign a_ready  = !out_valid || out_ready;
  assign m_ready  = !m_valid || a_ready;
  assign in_ready = m_ready;

  always_comb begin
    prod = PROD_W'(in_item.quo) * PROD_W'(EIGHTH);
  end

  always_comb begin
    base_c = CALC_W'(base);
    case (code)
      oda_pkg::FLAGS_NONE:     angle_next = QUARTER_C - base_c;
      oda_pkg::FLAGS_X:        angle_next = THREEQ_C + base_c;
      oda_pkg::FLAGS_Y:        angle_next = QUARTER_C + base_c;
      oda_pkg::FLAGS_XY:       angle_next = THREEQ_C - base_c;
      oda_pkg::FLAGS_STEEP:    angle_next = base_c;
      oda_pkg::FLAGS_STEEP_X:  angle_next = FULL_C - base_c;
      oda_pkg::FLAGS_STEEP_Y:  angle_next = HALF_C - base_c;
      oda_pkg::FLAGS_STEEP_XY: angle_next = HALF_C + base_c;
      default:                 angle_next = base_c;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (m_ready) m_valid <= in_valid;
      if (a_ready) out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && in_valid) begin
      base <= prod[oda_pkg::FRAC_BITS +: BASE_W];
      code <= in_item.flags;
    end
    if (a_ready && m_valid) begin
      angle <= angle_next;
    end
  end

  // a full turn passes through unwrapped, wider turns are cut to the port
  assign direction_angle = angle[oda_pkg::ANGLE_W-1:0];

  `ODA_ASSERT_SAME(a_scale_base, m_valid, CALC_W'(base) <= CALC_W'(EIGHTH),
    "base angle above an eighth turn")
  `ODA_ASSERT_SAME(a_scale_angle, out_valid, angle <= FULL_C,
    "angle above a full turn")

endmodule
